// File: rtl/bscm_pkg.sv
// ----------------------------------------------------------------------------
// bscm_pkg
// Shared types, register indexes, reset values and the LiPo curve table for
// the battery state-of-charge and charge-cycle monitor.
// ----------------------------------------------------------------------------
package bscm_pkg;

   // Curve geometry
   localparam int CURVE_POINTS = 13;
   localparam int SEG_W        = $clog2(CURVE_POINTS);
   localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(CURVE_POINTS - 2);

   // Register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_DIVIDER_RATIO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_CELL_MV  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EMPTY_CELL_MV = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_PCT       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CRIT_PCT      = 3'd5;
   localparam int CSR_DATA_W = 13;

   // Register reset values
   localparam logic [11:0] RST_DIVIDER_RATIO = 12'd512;
   localparam logic [3:0]  RST_CELL_COUNT    = 4'd3;
   localparam logic [12:0] RST_FULL_CELL_MV  = 13'd4200;
   localparam logic [12:0] RST_EMPTY_CELL_MV = 13'd3200;
   localparam logic [6:0]  RST_LOW_PCT       = 7'd20;
   localparam logic [6:0]  RST_CRIT_PCT      = 7'd10;

   // Fixed thresholds
   localparam logic [6:0]  PCT_FULL       = 7'd100;
   localparam logic [6:0]  PCT_EMPTY      = 7'd0;
   localparam logic [6:0]  PCT_CYCLE_HIGH = 7'd95;
   localparam logic [31:0] CRIT_HOLDOFF_MS = 32'd1000;
   localparam logic [31:0] LOW_HOLDOFF_MS  = 32'd5000;

   // Warning levels
   localparam logic [1:0] WARN_NONE = 2'd0;
   localparam logic [1:0] WARN_LOW  = 2'd1;
   localparam logic [1:0] WARN_CRIT = 2'd2;

   typedef struct packed {
      logic [11:0] adc_mv;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] pack_mv;
      logic [15:0] cell_mv;
      logic [6:0]  soc_pct;
      logic [31:0] cycle_count;
      logic        cycle_done;
      logic [1:0]  warn_level;
      logic        warn_emit;
   } rsp_payload_type;

   // Status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } srl_stat_type;

   // Curve point voltage in mV, indexed from the full end
   function automatic logic [12:0] curve_mv(input logic [SEG_W-1:0] idx);
      logic [12:0] mv;
      case (idx)
         4'd0:    mv = 13'd4200;
         4'd1:    mv = 13'd4100;
         4'd2:    mv = 13'd4000;
         4'd3:    mv = 13'd3920;
         4'd4:    mv = 13'd3850;
         4'd5:    mv = 13'd3790;
         4'd6:    mv = 13'd3740;
         4'd7:    mv = 13'd3700;
         4'd8:    mv = 13'd3660;
         4'd9:    mv = 13'd3600;
         4'd10:   mv = 13'd3500;
         4'd11:   mv = 13'd3300;
         4'd12:   mv = 13'd3200;
         default: mv = 13'd0;
      endcase
      return mv;
   endfunction

   // Curve point charge in percent
   function automatic logic [6:0] curve_pct(input logic [SEG_W-1:0] idx);
      logic [6:0] pct;
      case (idx)
         4'd0:    pct = 7'd100;
         4'd1:    pct = 7'd95;
         4'd2:    pct = 7'd85;
         4'd3:    pct = 7'd75;
         4'd4:    pct = 7'd65;
         4'd5:    pct = 7'd55;
         4'd6:    pct = 7'd45;
         4'd7:    pct = 7'd35;
         4'd8:    pct = 7'd25;
         4'd9:    pct = 7'd15;
         4'd10:   pct = 7'd8;
         4'd11:   pct = 7'd3;
         4'd12:   pct = 7'd0;
         default: pct = 7'd0;
      endcase
      return pct;
   endfunction

endpackage

// File: rtl/bscm_ser_mul.sv
// ----------------------------------------------------------------------------
// bscm_ser_mul
// Shift-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module bscm_ser_mul import bscm_pkg::*; #(
   parameter int A_W = 12,
   parameter int B_W = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     mcand,
   input  logic [B_W-1:0]     mplier,
   output logic [A_W+B_W-1:0] product,
   output srl_stat_type       stat
);

   localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [A_W-1:0]   mcand_ff, mcand_in;
   logic [A_W-1:0]   hi_ff, hi_in;
   logic [B_W-1:0]   lo_ff, lo_in;
   logic [A_W:0]     sum;

   // Add the multiplicand when the low bit is set, then shift right
   always_comb begin
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplier;
      end else if (busy_ff) begin
         hi_in  = sum[A_W:1];
         lo_in  = {sum[0], lo_ff[B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign product   = {hi_ff, lo_ff};
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/bscm_ser_div.sv
// ----------------------------------------------------------------------------
// bscm_ser_div
// Restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bscm_ser_div import bscm_pkg::*; #(
   parameter int N_W = 16,
   parameter int D_W = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic [N_W-1:0] quotient,
   output srl_stat_type   stat
);

   localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   dvs_ff, dvs_in;
   logic [D_W:0]     shifted;
   logic [D_W:0]     trial;

   // Shift in the next dividend bit and subtract when it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[N_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial[D_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[D_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/battery_soc_cycle_monitor.sv
// ----------------------------------------------------------------------------
// battery_soc_cycle_monitor
// Pack and cell voltage, LiPo state of charge, charge-cycle count and
// rate-limited low and critical warnings, one result word per reading.
// ----------------------------------------------------------------------------
// One reading is processed at a time, and each yields one result word. The
// work is a shift-add multiply for the pack voltage, a restoring divide by
// the cell count, a scan of the curve at one segment per cycle, and a second
// multiply and divide for the interpolation; readings clamped at the full or
// empty threshold skip the last three steps. A finished result waits in an
// output register, and the next reading is taken while it waits. Registers
// are to be written through the csr port only while no reading is in flight;
// the user must keep to this, as the block itself does not enforce it.
module battery_soc_cycle_monitor import bscm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_MUL_PACK = 8'b0000_0010,
      S_DIV_CELL = 8'b0000_0100,
      S_CLAMP    = 8'b0000_1000,
      S_SCAN     = 8'b0001_0000,
      S_MUL_NUM  = 8'b0010_0000,
      S_DIV_DROP = 8'b0100_0000,
      S_FIN      = 8'b1000_0000
   } state_type;

   // Configuration registers
   logic [11:0] ratio_ff;
   logic [3:0]  cells_ff;
   logic [12:0] full_ff;
   logic [12:0] empty_ff;
   logic [6:0]  low_ff;
   logic [6:0]  crit_ff;

   // Control and monitor state
   state_type        state_ff, state_in;
   logic [SEG_W-1:0] seg_ff, seg_in;
   logic             disch_ff, disch_in;
   logic [31:0]      cycle_ff, cycle_in;
   logic [31:0]      last_warn_ff, last_warn_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Per-reading working registers
   logic [31:0]     now_ff, now_in;
   logic [15:0]     pack_ff, pack_in;
   logic [15:0]     cell_ff, cell_in;
   logic [6:0]      soc_ff, soc_in;
   rsp_payload_type rsp_ff, rsp_in;

   // Serial units
   logic               mul_start;
   logic [11:0]        mul_a;
   logic [11:0]        mul_b;
   logic [23:0]        mul_prod;
   srl_stat_type       mul_stat;
   logic               div_start;
   logic [15:0]        div_num;
   logic [7:0]         div_den;
   logic [15:0]        div_quo;
   srl_stat_type       div_stat;

   // Segment arithmetic
   logic [3:0]  cells_eff;
   logic [12:0] a_mv, b_mv;
   logic [6:0]  a_pct, b_pct;
   logic [6:0]  seg_dp;
   logic [12:0] seg_dmv;
   logic [12:0] seg_den;
   logic        seg_hit;
   logic [15:0] drop_num;
   logic [6:0]  drop;

   // Final update
   logic [31:0] elapsed;
   logic        fin_go;
   logic [1:0]  level;
   logic        emit;
   logic        done;

   bscm_ser_mul #(.A_W(12), .B_W(12)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .product (mul_prod),
      .stat    (mul_stat)
   );

   bscm_ser_div #(.N_W(16), .D_W(8)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // Look up the current curve segment
   always_comb begin
      cells_eff = (cells_ff == 4'd0) ? 4'd1 : cells_ff;
      a_mv      = curve_mv(seg_ff);
      b_mv      = curve_mv(seg_ff + 1'b1);
      a_pct     = curve_pct(seg_ff);
      b_pct     = curve_pct(seg_ff + 1'b1);
      seg_dp    = (a_pct >= b_pct) ? (a_pct - b_pct) : 7'd0;
      seg_dmv   = a_mv - cell_ff[12:0];
      seg_den   = a_mv - b_mv;
      seg_hit   = (cell_ff <= {3'd0, a_mv}) && (cell_ff >= {3'd0, b_mv}) && (a_mv > b_mv);
      drop_num  = mul_prod[15:0] + {3'd0, seg_den} - 16'd1;
      drop      = div_quo[6:0];
   end

   // Operand selection for the shared units
   always_comb begin
      mul_start = 1'b0;
      mul_a     = seg_dmv[11:0];
      mul_b     = {5'd0, seg_dp};
      div_start = 1'b0;
      div_num   = drop_num;
      div_den   = seg_den[7:0];
      case (state_ff)
         S_IDLE: begin
            mul_start = req_valid;
            mul_a     = req_data.adc_mv;
            mul_b     = ratio_ff;
         end
         S_MUL_PACK: begin
            div_start = mul_stat.done;
            div_num   = mul_prod[23:8];
            div_den   = {4'd0, cells_eff};
         end
         S_SCAN: begin
            mul_start = seg_hit;
         end
         S_MUL_NUM: begin
            div_start = mul_stat.done;
         end
         default: begin
         end
      endcase
   end

   // Rate-limited warning and cycle hysteresis for the finished reading
   always_comb begin
      elapsed  = now_ff - last_warn_ff;
      level    = WARN_NONE;
      emit     = 1'b0;
      done     = 1'b0;
      disch_in = disch_ff;
      cycle_in = cycle_ff;
      last_warn_in = last_warn_ff;
      if (!disch_ff && (soc_ff < low_ff)) begin
         disch_in = 1'b1;
      end else if (disch_ff && (soc_ff > PCT_CYCLE_HIGH)) begin
         disch_in = 1'b0;
         cycle_in = cycle_ff + 32'd1;
         done     = 1'b1;
      end
      if (soc_ff < crit_ff) begin
         level = WARN_CRIT;
         if (elapsed > CRIT_HOLDOFF_MS) begin
            emit         = 1'b1;
            last_warn_in = now_ff;
         end
      end else if (soc_ff < low_ff) begin
         level = WARN_LOW;
         if (elapsed > LOW_HOLDOFF_MS) begin
            emit         = 1'b1;
            last_warn_in = now_ff;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      seg_in       = seg_ff;
      now_in       = now_ff;
      pack_in      = pack_ff;
      cell_in      = cell_ff;
      soc_in       = soc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      fin_go       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in   = req_data.now_ms;
               state_in = S_MUL_PACK;
            end
         end
         S_MUL_PACK: begin
            if (mul_stat.done) begin
               pack_in  = mul_prod[23:8];
               state_in = S_DIV_CELL;
            end
         end
         S_DIV_CELL: begin
            if (div_stat.done) begin
               cell_in  = div_quo;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            seg_in = '0;
            if (cell_ff >= {3'd0, full_ff}) begin
               soc_in   = PCT_FULL;
               state_in = S_FIN;
            end else if (cell_ff <= {3'd0, empty_ff}) begin
               soc_in   = PCT_EMPTY;
               state_in = S_FIN;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (seg_hit) begin
               state_in = S_MUL_NUM;
            end else if (seg_ff == SEG_LAST) begin
               soc_in   = PCT_EMPTY;
               state_in = S_FIN;
            end else begin
               seg_in = seg_ff + 1'b1;
            end
         end
         S_MUL_NUM: begin
            if (mul_stat.done) begin
               state_in = S_DIV_DROP;
            end
         end
         S_DIV_DROP: begin
            if (div_stat.done) begin
               soc_in   = (drop <= a_pct) ? (a_pct - drop) : PCT_EMPTY;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               fin_go              = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_in.pack_mv      = pack_ff;
               rsp_in.cell_mv      = cell_ff;
               rsp_in.soc_pct      = soc_ff;
               rsp_in.cycle_count  = cycle_in;
               rsp_in.cycle_done   = done;
               rsp_in.warn_level   = level;
               rsp_in.warn_emit    = emit;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seg_ff       <= '0;
         disch_ff     <= 1'b0;
         cycle_ff     <= '0;
         last_warn_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fin_go) begin
            disch_ff     <= disch_in;
            cycle_ff     <= cycle_in;
            last_warn_ff <= last_warn_in;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      now_ff  <= now_in;
      pack_ff <= pack_in;
      cell_ff <= cell_in;
      soc_ff  <= soc_in;
      rsp_ff  <= rsp_in;
   end

   // Configuration writes, masked to register width
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RST_DIVIDER_RATIO;
         cells_ff <= RST_CELL_COUNT;
         full_ff  <= RST_FULL_CELL_MV;
         empty_ff <= RST_EMPTY_CELL_MV;
         low_ff   <= RST_LOW_PCT;
         crit_ff  <= RST_CRIT_PCT;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DIVIDER_RATIO: ratio_ff <= csr_wdata[11:0];
            REG_CELL_COUNT:    cells_ff <= csr_wdata[3:0];
            REG_FULL_CELL_MV:  full_ff  <= csr_wdata[12:0];
            REG_EMPTY_CELL_MV: empty_ff <= csr_wdata[12:0];
            REG_LOW_PCT:       low_ff   <= csr_wdata[6:0];
            REG_CRIT_PCT:      crit_ff  <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A new result word only ever comes from the final step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result word appeared outside the final step");

   // The multiplier is working or finishing whenever the sequencer waits on it
   a_mul_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_PACK || state_ff == S_MUL_NUM) |-> (mul_stat.busy || mul_stat.done))
      else $error("sequencer waits on an idle multiplier");

   // The divider is working or finishing whenever the sequencer waits on it
   a_div_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_CELL || state_ff == S_DIV_DROP) |-> (div_stat.busy || div_stat.done))
      else $error("sequencer waits on an idle divider");

   // The cycle counter only ever steps by one
   a_cycle_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (cycle_ff != $past(cycle_ff))) |-> (cycle_ff == $past(cycle_ff) + 32'd1))
      else $error("cycle counter jumped");

   // A result never reports charge above full, nor a warning without a level
   a_rsp_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.soc_pct <= PCT_FULL) &&
                        (!rsp_ff.warn_emit || (rsp_ff.warn_level != WARN_NONE))))
      else $error("result word out of range");

endmodule
